// File: hdl/mad_pkg.sv
// types and constants shared by the dissimilarity block
package mad_pkg;

    typedef struct packed {
        logic [15:0] brand_id;
        logic [15:0] os_id;
        logic        fast_charge;
        logic        dual_sim;
        logic [7:0]  cpu_rank;
        logic [11:0] screen_size;
        logic [15:0] storage_size;
        logic [9:0]  memory_size;
        logic [15:0] battery;
        logic [23:0] price;
    } rec_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_TERM = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_MEAN = 7'b0010000,
        ST_MUL  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    localparam int NUM_FIELDS   = 5;
    localparam logic [2:0] TERM_RANK = 3'd5;
    localparam logic [7:0] TOP_RANK_RESET = 8'd5;
    localparam logic [23:0] MIN_RESET = 24'hFFFFFF;
    localparam logic [19:0] ROUND_HALF = 20'd5;
    // ceil(2^23 / 10), exact for sums below 2^22
    localparam logic [19:0] RECIP_TEN = 20'd838861;
    localparam int RECIP_SHIFT = 23;
    localparam logic CMD_LOAD = 1'b0;

    function automatic logic [23:0] num_field(rec_t r, logic [2:0] f);
        logic [23:0] v;
        case (f)
            3'd0: v = r.price;
            3'd1: v = {8'd0, r.battery};
            3'd2: v = {14'd0, r.memory_size};
            3'd3: v = {8'd0, r.storage_size};
            3'd4: v = {12'd0, r.screen_size};
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/mad_div.sv
// restoring divider: floor(diff * 2^16 / range) for diff <= range, one bit a cycle
module mad_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] diff,
    input  logic [23:0] range,
    output logic        done,
    output logic [16:0] quot
);
    logic [24:0] rem_reg, rem_next;
    logic [23:0] div_reg;
    logic [16:0] q_reg;
    logic [4:0]  step_reg;
    logic        busy_reg, done_reg;
    logic [24:0] trial;
    logic        qbit;

    always_comb begin
        trial    = (step_reg == 5'd0) ? rem_reg : {rem_reg[23:0], 1'b0};
        qbit     = trial >= {1'b0, div_reg};
        rem_next = qbit ? trial - {1'b0, div_reg} : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 5'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'd16) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, diff};
            div_reg <= range;
            q_reg   <= 17'd0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[15:0], qbit};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// File: hdl/mixed_attribute_dissimilarity.sv
// top level of the mixed-attribute dissimilarity engine
// A load transfer (tuser 0) stores one record and updates the per-field
// minimum and maximum; loads beyond MAX_ITEMS are dropped. A compute transfer (tuser 1)
// walks every stored pair with row > col, row-major, and emits one result each, tlast on
// the final pair, then empties the store; with fewer than two records it only empties
// the store. Each pair runs up to six divisions (five numeric terms and the rank term)
// through one shared restoring divider; a division is started from the term state, runs
// 17 quotient steps and then reports done, while a term with zero range skips the divider.
// The pair is read before its terms, the mean and multiply steps follow them, and the
// result waits for m_tready. The block takes no input while a compute run is in progress.
module mixed_attribute_dissimilarity #(
    parameter int MAX_ITEMS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,    // cpu_top_rank
    input  logic         s_tvalid,
    output logic         s_tready,
    // price, battery, memory_size, storage_size, screen_size, cpu_rank, dual_sim,
    // fast_charge, os_id, brand_id
    input  logic [119:0] s_tdata,
    input  logic         s_tuser,        // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,        // row, col, dissimilarity, zero fill
    output logic         m_tlast
);
    localparam int AW = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    mad_pkg::state_t state_reg, state_next;
    mad_pkg::rec_t   mem [MAX_ITEMS];
    mad_pkg::rec_t   rec_a_reg, rec_b_reg, in_rec;

    logic [7:0]  top_rank_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] row_reg, col_reg;
    logic [2:0]  term_reg;
    logic [19:0] sum_reg, mean_reg;
    logic [39:0] prod_reg;
    logic [23:0] min_reg [mad_pkg::NUM_FIELDS];
    logic [23:0] max_reg [mad_pkg::NUM_FIELDS];

    logic        load_xfer, cmd_xfer, out_xfer, full, last_pair, col_end;
    logic [23:0] a_val, b_val, diff, range, lo, hi;
    logic [7:0]  ra, rb;
    logic        div_start, div_done;
    logic [16:0] div_quot;
    logic [2:0]  mism;

    assign in_rec    = mad_pkg::rec_t'(s_tdata);
    assign s_tready  = (state_reg == mad_pkg::ST_IDLE);
    assign load_xfer = s_tvalid && s_tready && (s_tuser == mad_pkg::CMD_LOAD);
    assign cmd_xfer  = s_tvalid && s_tready && (s_tuser != mad_pkg::CMD_LOAD);
    assign full      = (count_reg == CW'(MAX_ITEMS));
    assign m_tvalid  = (state_reg == mad_pkg::ST_OUT);
    assign out_xfer  = m_tvalid && m_tready;
    assign col_end   = (col_reg == row_reg - AW'(1));
    assign last_pair = col_end && (CW'(row_reg) == count_reg - CW'(1));

    // operands of the current term
    always_comb begin
        ra = (rec_a_reg.cpu_rank < top_rank_reg) ? rec_a_reg.cpu_rank : top_rank_reg;
        rb = (rec_b_reg.cpu_rank < top_rank_reg) ? rec_b_reg.cpu_rank : top_rank_reg;
        if (term_reg == mad_pkg::TERM_RANK) begin
            a_val = {16'd0, ra};
            b_val = {16'd0, rb};
            lo    = 24'd0;
            hi    = {16'd0, top_rank_reg};
        end else begin
            a_val = mad_pkg::num_field(rec_a_reg, term_reg);
            b_val = mad_pkg::num_field(rec_b_reg, term_reg);
            lo    = min_reg[term_reg];
            hi    = max_reg[term_reg];
        end
        diff  = (a_val > b_val) ? a_val - b_val : b_val - a_val;
        range = (hi >= lo) ? hi - lo : 24'd0;
    end

    assign div_start = (state_reg == mad_pkg::ST_TERM) && (range != 24'd0);
    assign mism = 3'(rec_a_reg.dual_sim != rec_b_reg.dual_sim)
                + 3'(rec_a_reg.fast_charge != rec_b_reg.fast_charge)
                + 3'(rec_a_reg.os_id != rec_b_reg.os_id)
                + 3'(rec_a_reg.brand_id != rec_b_reg.brand_id);

    mad_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .diff    (diff),
        .range   (range),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mad_pkg::ST_IDLE: begin
                if (cmd_xfer && count_reg >= CW'(2)) state_next = mad_pkg::ST_READ;
            end
            mad_pkg::ST_READ: state_next = mad_pkg::ST_TERM;
            mad_pkg::ST_TERM: begin
                if (range != 24'd0) state_next = mad_pkg::ST_DIV;
                else if (term_reg == mad_pkg::TERM_RANK) state_next = mad_pkg::ST_MEAN;
            end
            mad_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = (term_reg == mad_pkg::TERM_RANK) ? mad_pkg::ST_MEAN
                                                                  : mad_pkg::ST_TERM;
                end
            end
            mad_pkg::ST_MEAN: state_next = mad_pkg::ST_MUL;
            mad_pkg::ST_MUL:  state_next = mad_pkg::ST_OUT;
            mad_pkg::ST_OUT: begin
                if (m_tready) state_next = last_pair ? mad_pkg::ST_IDLE : mad_pkg::ST_READ;
            end
            default: state_next = mad_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mad_pkg::ST_IDLE;
            top_rank_reg <= mad_pkg::TOP_RANK_RESET;
            count_reg    <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            term_reg     <= 3'd0;
            for (int f = 0; f < mad_pkg::NUM_FIELDS; f++) begin
                min_reg[f] <= mad_pkg::MIN_RESET;
                max_reg[f] <= 24'd0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) top_rank_reg <= cfg_wr_data;
            if (load_xfer && !full) begin
                count_reg <= count_reg + CW'(1);
                for (int f = 0; f < mad_pkg::NUM_FIELDS; f++) begin
                    if (mad_pkg::num_field(in_rec, 3'(f)) > max_reg[f])
                        max_reg[f] <= mad_pkg::num_field(in_rec, 3'(f));
                    if (mad_pkg::num_field(in_rec, 3'(f)) < min_reg[f])
                        min_reg[f] <= mad_pkg::num_field(in_rec, 3'(f));
                end
            end
            // empty the store after a compute run, or at once with fewer than two records
            if ((cmd_xfer && count_reg < CW'(2)) || (out_xfer && last_pair)) begin
                count_reg <= '0;
                for (int f = 0; f < mad_pkg::NUM_FIELDS; f++) begin
                    min_reg[f] <= mad_pkg::MIN_RESET;
                    max_reg[f] <= 24'd0;
                end
            end
            if (cmd_xfer) begin
                row_reg <= AW'(1);
                col_reg <= '0;
            end else if (out_xfer && !last_pair) begin
                if (col_end) begin
                    row_reg <= row_reg + AW'(1);
                    col_reg <= '0;
                end else begin
                    col_reg <= col_reg + AW'(1);
                end
            end
            if (state_reg == mad_pkg::ST_READ) term_reg <= 3'd0;
            else if ((state_reg == mad_pkg::ST_TERM && range == 24'd0)
                     || (state_reg == mad_pkg::ST_DIV && div_done))
                term_reg <= term_reg + 3'd1;
        end
    end

    // record store and datapath registers
    always_ff @(posedge aclk) begin
        if (load_xfer && !full) mem[count_reg[AW-1:0]] <= in_rec;
        rec_a_reg <= mem[row_reg];
        rec_b_reg <= mem[col_reg];
        if (state_reg == mad_pkg::ST_READ) sum_reg <= 20'd0;
        else if (state_reg == mad_pkg::ST_DIV && div_done)
            sum_reg <= sum_reg + {3'd0, div_quot};
        if (state_reg == mad_pkg::ST_MEAN)
            mean_reg <= sum_reg + {1'b0, mism, 16'd0} + mad_pkg::ROUND_HALF;
        if (state_reg == mad_pkg::ST_MUL) prod_reg <= mean_reg * mad_pkg::RECIP_TEN;
    end

    assign m_tdata = {7'd0, prod_reg[mad_pkg::RECIP_SHIFT +: 17], 4'(col_reg), 4'(row_reg)};
    assign m_tlast = last_pair;

    a_no_input_during_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result is pending");
    a_row_above_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (row_reg > col_reg) && (CW'(row_reg) < count_reg))
        else $error("pair indices out of order");
    a_cleared_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_xfer && m_tlast) |=> (count_reg == '0) && s_tready)
        else $error("store not emptied after the final pair");
    a_div_start_in_term: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> (state_reg == mad_pkg::ST_DIV))
        else $error("divider started outside term setup");
endmodule

// File: test/tb.sv
// testbench for the mixed-attribute dissimilarity engine: random and directed records
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITEMS = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD = 400;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef struct {
        logic cmd;
        mad_pkg::rec_t rec;
    } item_t;

    typedef struct {
        logic [3:0]  row;
        logic [3:0]  col;
        logic [16:0] dis;
        logic        last;
    } pair_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [7:0]   cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic         m_tlast;

    mixed_attribute_dissimilarity #(.MAX_ITEMS(MAX_ITEMS)) dut (.*);

    always #6 aclk = ~aclk;

    item_t pending[$];
    pair_t expected_pairs[$];

    // predictor state
    mad_pkg::rec_t records[MAX_ITEMS];
    int unsigned rec_count = 0;
    logic [23:0] fmin[mad_pkg::NUM_FIELDS] = '{default: mad_pkg::MIN_RESET};
    logic [23:0] fmax[mad_pkg::NUM_FIELDS] = '{default: 24'd0};
    logic [7:0]  top_rank = mad_pkg::TOP_RANK_RESET;

    int  mismatches = 0;
    int  pairs_seen = 0;
    int  idle_cycles = 0;
    bit  quiet = 0;
    int  in_total = 0;
    int  in_seen = 0;
    int  out_total = 0;
    int  out_seen = 0;
    bit  hold_req = 0;
    bit  hold_done = 0;
    int  s_gap = 0;
    int  r_gap = 0;
    int  hold_cnt = 0;

    function automatic int next_gap();
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 65) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [23:0] field_of(mad_pkg::rec_t r, int f);
        case (f)
            0: return r.price;
            1: return 24'(r.battery);
            2: return 24'(r.memory_size);
            3: return 24'(r.storage_size);
            default: return 24'(r.screen_size);
        endcase
    endfunction

    function automatic longint unsigned q16_ratio(longint unsigned d, longint unsigned rng);
        longint unsigned q;
        if (rng == 0) return 0;
        q = (d << 16) / rng;
        return (q > 65536) ? 65536 : q;
    endfunction

    function automatic longint unsigned absdiff(longint unsigned a, longint unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [16:0] pair_mean(mad_pkg::rec_t a, mad_pkg::rec_t b);
        longint unsigned sum, rng, ra, rb;
        sum = 0;
        for (int f = 0; f < mad_pkg::NUM_FIELDS; f++) begin
            rng = (fmax[f] >= fmin[f]) ? fmax[f] - fmin[f] : 0;
            sum += q16_ratio(absdiff(field_of(a, f), field_of(b, f)), rng);
        end
        ra = (a.cpu_rank < top_rank) ? a.cpu_rank : top_rank;
        rb = (b.cpu_rank < top_rank) ? b.cpu_rank : top_rank;
        sum += q16_ratio(absdiff(ra, rb), top_rank);
        sum += (a.dual_sim != b.dual_sim) ? 65536 : 0;
        sum += (a.fast_charge != b.fast_charge) ? 65536 : 0;
        sum += (a.os_id != b.os_id) ? 65536 : 0;
        sum += (a.brand_id != b.brand_id) ? 65536 : 0;
        return 17'((sum + 5) / 10);
    endfunction

    function automatic void clear_records();
        rec_count = 0;
        for (int f = 0; f < mad_pkg::NUM_FIELDS; f++) begin
            fmin[f] = mad_pkg::MIN_RESET;
            fmax[f] = '0;
        end
    endfunction

    function automatic void predict_transfer(logic cmd, mad_pkg::rec_t r);
        pair_t p;
        int unsigned total, k;
        logic [23:0] v;
        if (cmd == mad_pkg::CMD_LOAD) begin
            if (rec_count >= MAX_ITEMS) return;
            records[rec_count] = r;
            for (int f = 0; f < mad_pkg::NUM_FIELDS; f++) begin
                v = field_of(r, f);
                if (v > fmax[f]) fmax[f] = v;
                if (v < fmin[f]) fmin[f] = v;
            end
            rec_count++;
            return;
        end
        total = (rec_count >= 2) ? rec_count * (rec_count - 1) / 2 : 0;
        k = 0;
        for (int i = 1; i < rec_count; i++) begin
            for (int j = 0; j < i; j++) begin
                k++;
                p.row = 4'(i);
                p.col = 4'(j);
                p.dis = pair_mean(records[i], records[j]);
                p.last = (k == total);
                expected_pairs.push_back(p);
            end
        end
        clear_records();
    endfunction

    // field values lean toward extremes and repeats so equal values and zero ranges show up
    function automatic logic [23:0] pick(int width);
        int s;
        logic [23:0] ones;
        ones = 24'((32'd1 << width) - 32'd1);
        s = $urandom_range(0, 9);
        if (s == 0) return '0;
        if (s == 1) return ones;
        if (s < 4) return 24'($urandom_range(0, 3));
        return 24'($urandom) & ones;
    endfunction

    function automatic mad_pkg::rec_t random_record();
        mad_pkg::rec_t r;
        r.price        = pick(24);
        r.battery      = 16'(pick(16));
        r.memory_size  = 10'(pick(10));
        r.storage_size = 16'(pick(16));
        r.screen_size  = 12'(pick(12));
        r.cpu_rank     = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, top_rank + 2));
        r.dual_sim     = 1'($urandom);
        r.fast_charge  = 1'($urandom);
        r.os_id        = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 2)) : 16'($urandom);
        r.brand_id     = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 2)) : 16'($urandom);
        return r;
    endfunction

    task automatic queue_item(logic cmd, mad_pkg::rec_t r);
        item_t it;
        it.cmd = cmd;
        it.rec = r;
        pending.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || s_tvalid || expected_pairs.size() != 0)
            @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic write_top_rank(logic [7:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        top_rank = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // driver
    always @(negedge aclk) begin
        item_t it;
        if (aresetn && (!s_tvalid || in_total != in_seen)) begin
            in_seen = in_total;
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (pending.size() != 0) begin
                it = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= it.rec;
                s_tuser <= it.cmd;
                s_gap = next_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        bit got_one;
        if (aresetn) begin
            got_one = (out_total != out_seen);
            out_seen = out_total;
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (r_gap > 0) begin
                r_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (got_one) r_gap = next_gap();
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin
        pair_t got, exp_p;
        if (aresetn) begin
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                in_total++;
                idle_cycles = 0;
                predict_transfer(s_tuser, mad_pkg::rec_t'(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                out_total++;
                idle_cycles = 0;
                pairs_seen++;
                if (pairs_seen == 20) hold_req = 1;
                got.row = m_tdata[3:0];
                got.col = m_tdata[7:4];
                got.dis = m_tdata[24:8];
                got.last = m_tlast;
                if (expected_pairs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer row %0d col %0d dis %0d last %0d",
                                 got.row, got.col, got.dis, got.last);
                end else begin
                    exp_p = expected_pairs.pop_front();
                    if (got.row !== exp_p.row || got.col !== exp_p.col ||
                        got.dis !== exp_p.dis || got.last !== exp_p.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp row %0d col %0d dis %0d last %0d,",
                                      " got row %0d col %0d dis %0d last %0d"},
                                     exp_p.row, exp_p.col, exp_p.dis, exp_p.last,
                                     got.row, got.col, got.dis, got.last);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("mixed_attribute_dissimilarity verification failed");
                $finish;
            end
        end
    end

    initial begin
        mad_pkg::rec_t r;
        int nloads;
        logic [7:0] ranks[4];
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, full store with a dropped load, empty and single-record runs
        write_top_rank(8'd5);
        quiet = 1;
        r = '0;
        queue_item(mad_pkg::CMD_LOAD, r);
        queue_item(mad_pkg::CMD_LOAD, '1);
        r = '0;
        r.cpu_rank = 8'd200;
        r.os_id = 16'hFFFF;
        queue_item(mad_pkg::CMD_LOAD, r);
        for (int i = 0; i < 6; i++) queue_item(mad_pkg::CMD_LOAD, random_record());
        queue_item(CMD_COMPUTE, '0);
        queue_item(CMD_COMPUTE, '0);
        queue_item(mad_pkg::CMD_LOAD, random_record());
        queue_item(CMD_COMPUTE, '0);
        r = random_record();
        queue_item(mad_pkg::CMD_LOAD, r);
        queue_item(mad_pkg::CMD_LOAD, r);
        queue_item(CMD_COMPUTE, '0);
        wait_idle();
        quiet = 0;

        ranks[0] = 8'd1;
        ranks[1] = 8'd255;
        ranks[2] = 8'($urandom_range(2, 254));
        ranks[3] = 8'd3;
        for (int ph = 0; ph < 4; ph++) begin
            write_top_rank(ranks[ph]);
            quiet = (ph == 2);
            for (int s = 0; s < 3; s++) begin
                nloads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10)
                                                      : $urandom_range(7, 9);
                for (int i = 0; i < nloads; i++)
                    queue_item(mad_pkg::CMD_LOAD, random_record());
                queue_item(CMD_COMPUTE, '0);
            end
            wait_idle();
        end

        repeat (50) @(negedge aclk);
        if (mismatches == 0 && expected_pairs.size() == 0)
            $display("mixed_attribute_dissimilarity verification clean");
        else
            $display("mixed_attribute_dissimilarity verification failed");
        $finish;
    end

endmodule
